/* design/owm_pkg.sv */
package owm_pkg;

   localparam int CFG_BITS = 10;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_RESET = 3'd1,
      OP_WBIT  = 3'd2,
      OP_RBIT  = 3'd3,
      OP_WBYTE = 3'd4,
      OP_RBYTE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_RST_LOW   = 3'd1,
      PH_RST_WAIT  = 3'd2,
      PH_RST_TAIL  = 3'd3,
      PH_BIT_LOW   = 3'd4,
      PH_READ_WAIT = 3'd5,
      PH_RECOVER   = 3'd6
   } phase_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_PRESENCE_WAIT = 3'd1,
      CSR_RESET_TAIL    = 3'd2,
      CSR_SHORT_LOW     = 3'd3,
      CSR_WRITE0_LOW    = 3'd4,
      CSR_READ_SAMPLE   = 3'd5,
      CSR_SLOT          = 3'd6
   } csr_index_type;

   localparam logic [CFG_BITS-1:0] RESET_LOW_DEFAULT     = 10'd480;
   localparam logic [CFG_BITS-1:0] PRESENCE_WAIT_DEFAULT = 10'd70;
   localparam logic [CFG_BITS-1:0] RESET_TAIL_DEFAULT    = 10'd410;
   localparam logic [CFG_BITS-1:0] SHORT_LOW_DEFAULT     = 10'd6;
   localparam logic [CFG_BITS-1:0] WRITE0_LOW_DEFAULT    = 10'd60;
   localparam logic [CFG_BITS-1:0] READ_SAMPLE_DEFAULT   = 10'd9;
   localparam logic [CFG_BITS-1:0] SLOT_DEFAULT          = 10'd70;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_value;
      logic       cmd_error;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] reset_low_us;
      logic [CFG_BITS-1:0] presence_wait_us;
      logic [CFG_BITS-1:0] reset_tail_us;
      logic [CFG_BITS-1:0] short_low_us;
      logic [CFG_BITS-1:0] write0_low_us;
      logic [CFG_BITS-1:0] read_sample_us;
      logic [CFG_BITS-1:0] slot_us;
   } cfg_type;

endpackage

/* design/owm_csr.sv */
module owm_csr
   import owm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RESET_LOW:     cfg_in.reset_low_us     = csr_wdata;
            CSR_PRESENCE_WAIT: cfg_in.presence_wait_us = csr_wdata;
            CSR_RESET_TAIL:    cfg_in.reset_tail_us    = csr_wdata;
            CSR_SHORT_LOW:     cfg_in.short_low_us     = csr_wdata;
            CSR_WRITE0_LOW:    cfg_in.write0_low_us    = csr_wdata;
            CSR_READ_SAMPLE:   cfg_in.read_sample_us   = csr_wdata;
            CSR_SLOT:          cfg_in.slot_us          = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us     <= RESET_LOW_DEFAULT;
         cfg_ff.presence_wait_us <= PRESENCE_WAIT_DEFAULT;
         cfg_ff.reset_tail_us    <= RESET_TAIL_DEFAULT;
         cfg_ff.short_low_us     <= SHORT_LOW_DEFAULT;
         cfg_ff.write0_low_us    <= WRITE0_LOW_DEFAULT;
         cfg_ff.read_sample_us   <= READ_SAMPLE_DEFAULT;
         cfg_ff.slot_us          <= SLOT_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/owm_core.sv */
module owm_core
   import owm_pkg::*;
#(
   parameter int TIME_BITS = 10
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   // Comparisons are made at a width that holds both the timer and the
   // sum of two configuration values.
   localparam int WW = (TIME_BITS > CFG_BITS + 1) ? TIME_BITS : CFG_BITS + 1;
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [3:0]           bit_index_ff, bit_index_in;
   logic [7:0]           tx_shift_ff, tx_shift_in;
   logic [7:0]           rx_shift_ff, rx_shift_in;
   op_type               kind_ff, kind_in;
   logic                 sampled_ff, sampled_in;

   logic [TIME_BITS-1:0] el_inc;
   logic [WW-1:0]        short_c;
   logic [WW-1:0]        read_target;
   logic [WW-1:0]        low_target;
   logic                 is_read;
   logic                 done;
   logic                 err;
   logic [7:0]           rx;
   logic [3:0]           next_index;
   logic [7:0]           next_rx_shift;

   // A target beyond the timer's range is met once the timer saturates.
   function automatic logic reached(input logic [TIME_BITS-1:0] el,
                                    input logic [WW-1:0] target);
      logic r;
      r = (WW'(el) >= target) || (el == TMAX);
      return r;
   endfunction

   assign el_inc = (elapsed_ff == TMAX) ? elapsed_ff : elapsed_ff + TIME_BITS'(1);
   assign is_read = (kind_ff == OP_RBIT) || (kind_ff == OP_RBYTE);
   assign short_c = (WW'(cfg.short_low_us) > WW'(TMAX)) ? WW'(TMAX)
                                                         : WW'(cfg.short_low_us);
   assign read_target = short_c + WW'(cfg.read_sample_us);
   assign low_target = (is_read || tx_shift_ff[0]) ? WW'(cfg.short_low_us)
                                                   : WW'(cfg.write0_low_us);
   assign next_index = bit_index_ff + 4'd1;
   assign next_rx_shift = {sampled_ff, rx_shift_ff[7:1]};

   always_comb begin
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      bit_index_in = bit_index_ff;
      tx_shift_in  = tx_shift_ff;
      rx_shift_in  = rx_shift_ff;
      kind_in      = kind_ff;
      sampled_in   = sampled_ff;
      done         = 1'b0;
      err          = 1'b0;
      rx           = 8'd0;
      if (op_type'(req.opcode) != OP_TICK) begin
         if (req.opcode > OP_RBYTE || phase_ff != PH_IDLE) begin
            err = 1'b1;
         end else begin
            kind_in      = op_type'(req.opcode);
            elapsed_in   = '0;
            bit_index_in = 4'd0;
            sampled_in   = 1'b0;
            rx_shift_in  = 8'd0;
            tx_shift_in  = (op_type'(req.opcode) == OP_WBIT) ? {7'd0, req.data[0]}
                                                             : req.data;
            phase_in     = (op_type'(req.opcode) == OP_RESET) ? PH_RST_LOW
                                                              : PH_BIT_LOW;
         end
      end else if (phase_ff != PH_IDLE) begin
         elapsed_in = el_inc;
         unique case (phase_ff)
            PH_RST_LOW: begin
               if (reached(el_inc, WW'(cfg.reset_low_us))) begin
                  phase_in   = PH_RST_WAIT;
                  elapsed_in = '0;
               end
            end
            PH_RST_WAIT: begin
               if (reached(el_inc, WW'(cfg.presence_wait_us))) begin
                  sampled_in = ~req.line_level;
                  phase_in   = PH_RST_TAIL;
                  elapsed_in = '0;
               end
            end
            PH_RST_TAIL: begin
               if (reached(el_inc, WW'(cfg.reset_tail_us))) begin
                  phase_in   = PH_IDLE;
                  elapsed_in = '0;
                  done       = 1'b1;
                  rx         = {7'd0, sampled_ff};
               end
            end
            PH_BIT_LOW: begin
               if (reached(el_inc, low_target)) begin
                  phase_in = is_read ? PH_READ_WAIT : PH_RECOVER;
               end
            end
            PH_READ_WAIT: begin
               if (reached(el_inc, read_target)) begin
                  sampled_in = req.line_level;
                  phase_in   = PH_RECOVER;
               end
            end
            PH_RECOVER: begin
               if (reached(el_inc, WW'(cfg.slot_us))) begin
                  elapsed_in = '0;
                  if (kind_ff == OP_RBYTE) begin
                     rx_shift_in = next_rx_shift;
                  end
                  if (kind_ff == OP_WBYTE || kind_ff == OP_RBYTE) begin
                     tx_shift_in  = {1'b0, tx_shift_ff[7:1]};
                     bit_index_in = next_index;
                     if (next_index >= BITS_PER_BYTE) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                        rx       = (kind_ff == OP_RBYTE) ? next_rx_shift : 8'd0;
                     end else begin
                        phase_in = PH_BIT_LOW;
                     end
                  end else begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                     rx       = (kind_ff == OP_RBIT) ? {7'd0, sampled_ff} : 8'd0;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp.drive_low = (phase_in == PH_RST_LOW) || (phase_in == PH_BIT_LOW);
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.rx_value  = rx;
      rsp.cmd_error = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         bit_index_ff <= 4'd0;
         tx_shift_ff  <= 8'd0;
         rx_shift_ff  <= 8'd0;
         kind_ff      <= OP_TICK;
         sampled_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         bit_index_ff <= bit_index_in;
         tx_shift_ff  <= tx_shift_in;
         rx_shift_ff  <= rx_shift_in;
         kind_ff      <= kind_in;
         sampled_ff   <= sampled_in;
      end
   end

   // A rejected command leaves the sequencer exactly where it was.
   assert property (@(posedge clock) disable iff (reset)
      (step_en && err) |=> ($stable(phase_ff) && $stable(elapsed_ff)))
      else $error("rejected command changed the sequencer state");

   assert property (@(posedge clock) disable iff (reset)
      (step_en && done) |=> (phase_ff == PH_IDLE))
      else $error("completion reported while the sequencer stays busy");

   assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= BITS_PER_BYTE)
      else $error("bit index ran past a byte");

   assert property (@(posedge clock) disable iff (reset)
      (step_en && done) |-> !err)
      else $error("completion and rejection on the same beat");

endmodule

/* design/onewire_master_bus_engine.sv */
// Single-wire bus master sequencer.
// Request beats (req_valid/req_stall/req_data) carry either a one-microsecond
// tick with the sampled line level, or a command: bus reset, write bit, read
// bit, write byte or read byte. Every request beat yields exactly one response
// beat (rsp_valid/rsp_stall/rsp_data) with the line drive, busy and done flags,
// the received value on the completing beat, and an error flag for a command
// that arrived while busy or carried an unknown opcode.
// Timing registers are written through csr_valid/csr_ready, csr_index and
// csr_wdata; the user must write them only while the engine is idle, which
// the block itself leaves unchecked. csr_ready is always high. A request
// passes through an input register, then the sequencer update and a response
// register. One beat per cycle is taken for as long as the receiver keeps up,
// since the sequencer update is a single pass of short logic. When rsp_stall
// holds the response register full, req_stall rises only once the input
// register is also occupied. A synchronous reset empties both registers,
// returns the sequencer to idle and restores the default timing values.
module onewire_master_bus_engine
   import owm_pkg::*;
#(
   parameter int TIME_BITS = 10
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_rsp;
   cfg_type cfg;
   logic    out_free;
   logic    advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   owm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owm_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

endmodule
